// ===== rtl/nplab_pkg.sv =====
// ----------------------------------------------------------------------------
// nplab_pkg
// Shared types and constants for the nearest palette color search in CIE LAB.
// ----------------------------------------------------------------------------
package nplab_pkg;

    localparam int PALETTE_DEPTH = 16;
    localparam int LAB_FRAC_BITS = 4;

    // Widths derived from the palette depth.
    localparam int ADDR_W = $clog2(PALETTE_DEPTH);
    localparam int LEN_W  = $clog2(PALETTE_DEPTH + 1);

    // Fixed field widths.
    localparam int FUNC_W = 1;
    localparam int IDX_W  = 4;
    localparam int CFG_W  = 5;
    localparam int L_W    = 11;
    localparam int AB_W   = 12;

    // Magnitudes of channel differences and their squares.
    localparam int DL_W   = L_W;
    localparam int DAB_W  = AB_W;
    localparam int SQL_W  = 2 * DL_W;
    localparam int SQAB_W = 2 * DAB_W;
    localparam int DIST_W = SQAB_W + 2;

    localparam int S_TDATA_W = ((IDX_W + L_W + 2 * AB_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((IDX_W + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic        [L_W-1:0]  l;
        logic signed [AB_W-1:0] a;
        logic signed [AB_W-1:0] b;
    } lab_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] idx;
    } tag_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] idx;
        logic [DIST_W-1:0] sq_dist;
    } dist_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/nplab_palette.sv =====
// ----------------------------------------------------------------------------
// nplab_palette
// Palette store: one write port for loads, one registered read port for scans.
// ----------------------------------------------------------------------------
module nplab_palette (
    input  logic                   aclk,
    input  logic                   wr_en,
    input  logic [nplab_pkg::ADDR_W-1:0] wr_addr,
    input  nplab_pkg::lab_t        wr_data,
    input  logic                   rd_en,
    input  logic [nplab_pkg::ADDR_W-1:0] rd_addr,
    output nplab_pkg::lab_t        rd_data
);
    import nplab_pkg::*;

    lab_t mem [PALETTE_DEPTH];
    lab_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/nplab_dist.sv =====
// ----------------------------------------------------------------------------
// nplab_dist
// Shared distance unit: absolute differences, squares, then their sum, one
// palette entry per cycle through three register stages.
// ----------------------------------------------------------------------------
module nplab_dist (
    input  logic                aclk,
    input  logic                aresetn,
    input  nplab_pkg::lab_t     query,
    input  nplab_pkg::lab_t     entry,
    input  nplab_pkg::tag_t     in_tag,
    output nplab_pkg::dist_res_t res
);
    import nplab_pkg::*;

    logic signed [L_W:0]  dl;
    logic signed [AB_W:0] da;
    logic signed [AB_W:0] db;

    logic [DL_W-1:0]   abs_l_reg;
    logic [DAB_W-1:0]  abs_a_reg;
    logic [DAB_W-1:0]  abs_b_reg;
    logic [SQL_W-1:0]  sq_l_reg;
    logic [SQAB_W-1:0] sq_a_reg;
    logic [SQAB_W-1:0] sq_b_reg;
    logic [DIST_W-1:0] dist_reg;
    tag_t              tag1_reg;
    tag_t              tag2_reg;
    tag_t              tag3_reg;

    always_comb begin
        dl = $signed({1'b0, entry.l}) - $signed({1'b0, query.l});
        da = $signed({entry.a[AB_W-1], entry.a}) - $signed({query.a[AB_W-1], query.a});
        db = $signed({entry.b[AB_W-1], entry.b}) - $signed({query.b[AB_W-1], query.b});
    end

    always_ff @(posedge aclk) begin
        abs_l_reg <= dl[L_W]  ? DL_W'(-dl)  : DL_W'(dl);
        abs_a_reg <= da[AB_W] ? DAB_W'(-da) : DAB_W'(da);
        abs_b_reg <= db[AB_W] ? DAB_W'(-db) : DAB_W'(db);
        sq_l_reg  <= abs_l_reg * abs_l_reg;
        sq_a_reg  <= abs_a_reg * abs_a_reg;
        sq_b_reg  <= abs_b_reg * abs_b_reg;
        dist_reg  <= DIST_W'(sq_l_reg) + DIST_W'(sq_a_reg) + DIST_W'(sq_b_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg.valid <= 1'b0;
            tag2_reg.valid <= 1'b0;
            tag3_reg.valid <= 1'b0;
        end else begin
            tag1_reg.valid <= in_tag.valid;
            tag2_reg.valid <= tag1_reg.valid;
            tag3_reg.valid <= tag2_reg.valid;
        end
        tag1_reg.idx <= in_tag.idx;
        tag2_reg.idx <= tag1_reg.idx;
        tag3_reg.idx <= tag2_reg.idx;
    end

    assign res.valid   = tag3_reg.valid;
    assign res.idx     = tag3_reg.idx;
    assign res.sq_dist = dist_reg;

endmodule

// ===== rtl/nplab_ctrl.sv =====
// ----------------------------------------------------------------------------
// nplab_ctrl
// Sequencer: takes requests and configuration, walks the active entries
// through the distance unit, keeps the running minimum and holds the result.
// ----------------------------------------------------------------------------
module nplab_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [nplab_pkg::FUNC_W-1:0]  s_func,
    input  logic [nplab_pkg::IDX_W-1:0]   s_slot,
    input  nplab_pkg::lab_t               s_lab,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [nplab_pkg::CFG_W-1:0]   cfg_data,
    output logic                          wr_en,
    output logic [nplab_pkg::ADDR_W-1:0]  wr_addr,
    output nplab_pkg::lab_t               wr_data,
    output logic                          rd_en,
    output logic [nplab_pkg::ADDR_W-1:0]  rd_addr,
    output nplab_pkg::lab_t               query,
    output nplab_pkg::tag_t               ent_tag,
    input  nplab_pkg::dist_res_t          res,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [nplab_pkg::IDX_W-1:0]   m_index
);
    import nplab_pkg::*;

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [ADDR_W-1:0]  cnt_reg, cnt_next;
    lab_t               query_reg, query_next;
    logic [ADDR_W-1:0]  best_reg, best_next;
    logic [DIST_W-1:0]  best_dist_reg, best_dist_next;
    tag_t               tag_reg;
    logic               out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]   out_index_reg, out_index_next;
    logic [LEN_W-1:0]   last_idx;
    logic               accept;

    assign last_idx = len_reg - LEN_W'(1);
    assign accept   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= LEN_W'(PALETTE_DEPTH);
            out_valid_reg <= 1'b0;
            tag_reg.valid <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
            tag_reg.valid <= rd_en;
        end
        tag_reg.idx <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        query_reg     <= query_next;
        best_reg      <= best_next;
        best_dist_reg <= best_dist_next;
        out_index_reg <= out_index_next;
    end

    always_comb begin
        state_next     = state_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        query_next     = query_reg;
        best_next      = best_reg;
        best_dist_next = best_dist_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_index_next = out_index_reg;
        s_ready        = (state_reg == ST_IDLE);
        cfg_ready      = (state_reg == ST_IDLE);
        wr_en          = 1'b0;
        rd_en          = 1'b0;

        if (cfg_valid && cfg_ready) begin
            if (int'(cfg_data) > PALETTE_DEPTH) begin
                len_next = LEN_W'(PALETTE_DEPTH);
            end else begin
                len_next = LEN_W'(cfg_data);
            end
        end

        // Running minimum; the first entry always seeds it, so ties keep
        // the lowest index.
        if (res.valid && (res.idx == '0 || res.sq_dist < best_dist_reg)) begin
            best_next      = res.idx;
            best_dist_next = res.sq_dist;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_func == FUNC_LOAD) begin
                        wr_en = (int'(s_slot) < PALETTE_DEPTH);
                    end else if (len_reg == '0) begin
                        best_next  = '0;
                        state_next = ST_DONE;
                    end else begin
                        query_next = s_lab;
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                rd_en    = 1'b1;
                cnt_next = cnt_reg + ADDR_W'(1);
                if (LEN_W'(cnt_reg) == last_idx) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (res.valid && LEN_W'(res.idx) == last_idx) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_index_next = IDX_W'(best_reg);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign wr_addr = ADDR_W'(s_slot);
    assign wr_data = s_lab;
    assign rd_addr = cnt_reg;
    assign query   = query_reg;
    assign ent_tag = tag_reg;
    assign m_valid = out_valid_reg;
    assign m_index = out_index_reg;

endmodule

// ===== rtl/nearest_palette_color_lab.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_lab
// Nearest palette color search in CIE LAB over a 16-entry palette.
// ----------------------------------------------------------------------------
// A request with tuser 0 loads one palette entry and returns nothing. A
// request with tuser 1 returns the index of the active entry with the
// smallest squared LAB distance, the lowest index on a tie. During a
// query one shared subtract-square-sum unit visits one entry per cycle,
// behind a registered palette read and three pipeline stages.
// The input is not ready during a query; the result sits in an output
// register, so the next request is taken while it waits. Entries must be
// loaded before a query searches them. palette_length is written on the cfg
// channel while the block is idle; values above 16 are treated as 16.
// ----------------------------------------------------------------------------
module nearest_palette_color_lab (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // entry_index[3:0], l_value[14:4], a_value[26:15], b_value[38:27], zero pad
    input  logic [nplab_pkg::S_TDATA_W-1:0]   s_tdata,
    // func[0]
    input  logic [nplab_pkg::FUNC_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // nearest_index[3:0], zero pad
    output logic [nplab_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    // palette_length[4:0]
    input  logic [nplab_pkg::CFG_W-1:0]       cfg_data
);
    import nplab_pkg::*;

    logic [IDX_W-1:0]  s_slot;
    lab_t              s_lab;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    lab_t              wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    lab_t              rd_data;
    lab_t              query;
    tag_t              ent_tag;
    dist_res_t         res;
    logic [IDX_W-1:0]  m_index;

    assign s_slot  = s_tdata[IDX_W-1:0];
    assign s_lab.l = s_tdata[IDX_W +: L_W];
    assign s_lab.a = s_tdata[IDX_W + L_W +: AB_W];
    assign s_lab.b = s_tdata[IDX_W + L_W + AB_W +: AB_W];

    assign m_tdata = M_TDATA_W'(m_index);

    nplab_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_func    (s_tuser),
        .s_slot    (s_slot),
        .s_lab     (s_lab),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .query     (query),
        .ent_tag   (ent_tag),
        .res       (res),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_index   (m_index)
    );

    nplab_palette u_palette (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    nplab_dist u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .query   (query),
        .entry   (rd_data),
        .in_tag  (ent_tag),
        .res     (res)
    );

endmodule

// ===== verif/nearest_palette_color_lab_test.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_lab_test
// Self-checking testbench for the nearest palette color search in CIE LAB.
// ----------------------------------------------------------------------------
// The run loads all sixteen palette entries first, so that no query ever
// reads an unwritten entry. A directed table then covers the extremes of
// the channels, exact matches, ties, the empty palette and a saturated
// palette_length. After it come random phases. Each phase writes a new
// palette_length while the block is quiet and mixes loads with queries
// that hit entries exactly, land close to them, sit on the corners of the
// LAB range or are drawn at random. Each query's expected index is given
// or predicted on the spot and compared with the nearest_index returned.
// Sender gaps and receiver stalls change from phase to phase, and one
// long receiver stall backs the block up until it stops taking requests.
// ----------------------------------------------------------------------------
module nearest_palette_color_lab_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nplab_pkg::*;

    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 40;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 125;

    typedef enum logic {
        ROW_REQUEST,
        ROW_LENGTH
    } row_kind_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  slot;
        lab_t              color;
    } palette_req_t;

    typedef struct {
        row_kind_t        kind;
        palette_req_t     req;
        logic [CFG_W-1:0] length;
        bit               known;
        logic [IDX_W-1:0] known_index;
    } plan_row_t;

    typedef struct {
        logic [IDX_W-1:0] index;
        int               query_no;
    } pending_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [FUNC_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;

    // Shadow copy of the palette and the active length.
    lab_t                 palette_colors [PALETTE_DEPTH];
    logic [LEN_W-1:0]     active_length = LEN_W'(PALETTE_DEPTH);

    pending_t             pending_nearest [$];

    int                   queries_sent  = 0;
    int                   loads_sent    = 0;
    int                   length_writes = 0;
    int                   results_seen  = 0;
    int                   mismatches    = 0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   hold_asked    = 0;

    nearest_palette_color_lab uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // First active entry with the smallest squared LAB distance to q.
    function automatic logic [IDX_W-1:0] nearest_entry(lab_t q);
        int                dl;
        int                da;
        int                db;
        logic [DIST_W-1:0] sq_dist;
        logic [DIST_W-1:0] best_dist;
        logic [IDX_W-1:0]  best;
        best      = '0;
        best_dist = '0;
        for (int i = 0; i < int'(active_length); i++) begin
            dl      = int'(palette_colors[i].l) - int'(q.l);
            da      = int'($signed(palette_colors[i].a)) - int'($signed(q.a));
            db      = int'($signed(palette_colors[i].b)) - int'($signed(q.b));
            sq_dist = DIST_W'(dl * dl + da * da + db * db);
            if (i == 0 || sq_dist < best_dist) begin
                best_dist = sq_dist;
                best      = i[IDX_W-1:0];
            end
        end
        return best;
    endfunction

    function automatic plan_row_t request_row(logic [FUNC_W-1:0] func, int slot, int l,
                                              int a, int b, bit known, int known_index);
        plan_row_t r;
        r.kind          = ROW_REQUEST;
        r.req.func      = func;
        r.req.slot      = slot[IDX_W-1:0];
        r.req.color.l   = l[L_W-1:0];
        r.req.color.a   = a[AB_W-1:0];
        r.req.color.b   = b[AB_W-1:0];
        r.length        = '0;
        r.known         = known;
        r.known_index   = known_index[IDX_W-1:0];
        return r;
    endfunction

    function automatic plan_row_t length_row(int len);
        plan_row_t r;
        r             = request_row(FUNC_LOAD, 0, 0, 0, 0, 1'b0, 0);
        r.kind        = ROW_LENGTH;
        r.length      = len[CFG_W-1:0];
        return r;
    endfunction

    // Offers one request and updates the shadow palette or the expected
    // results at the edge where it is taken.
    task automatic send_request(palette_req_t req, bit known, logic [IDX_W-1:0] known_index);
        logic [S_TDATA_W-1:0] word;
        word                              = '0;
        word[IDX_W-1:0]                   = req.slot;
        word[IDX_W +: L_W]                = req.color.l;
        word[IDX_W + L_W +: AB_W]         = req.color.a;
        word[IDX_W + L_W + AB_W +: AB_W]  = req.color.b;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= req.func;
        do @(posedge aclk); while (!s_tready);
        if (req.func == FUNC_QUERY) begin
            pending_nearest.push_back('{index: known ? known_index : nearest_entry(req.color),
                                        query_no: queries_sent});
            queries_sent++;
        end else begin
            palette_colors[req.slot] = req.color;
            loads_sent++;
        end
    endtask

    // The length may only change while the block is quiet. A trailing load
    // leaves nothing to wait for, so a fixed settle time follows.
    task automatic write_palette_length(logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_nearest.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (value > PALETTE_DEPTH) begin
            active_length = LEN_W'(PALETTE_DEPTH);
        end else begin
            active_length = value;
        end
        length_writes++;
    endtask

    initial begin : result_sink
        pending_t want;
        int       hold_seen;
        int       hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (pending_nearest.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result with no query pending: nearest_index %0d",
                                 m_tdata[IDX_W-1:0]);
                    end
                end else begin
                    want = pending_nearest.pop_front();
                    results_seen++;
                    if (m_tdata[IDX_W-1:0] !== want.index) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("query %0d: nearest_index expected %0d, got %0d",
                                     want.query_no, want.index, m_tdata[IDX_W-1:0]);
                        end
                    end
                end
            end
            if (hold_seen != hold_asked) begin
                hold_seen = hold_asked;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : stimulus
        plan_row_t    directed_plan [$];
        int           phase_lengths [PHASES];
        palette_req_t req;
        int           pick;
        int           e;
        int           l;
        int           a;
        int           b;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FUNC_LOAD;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Every entry is written before anything searches it.
        directed_plan.push_back(request_row(FUNC_LOAD,  0,    0,     0,     0, 1'b0, 0));
        directed_plan.push_back(request_row(FUNC_LOAD,  1, 1600,  2047,  2047, 1'b0, 0));
        directed_plan.push_back(request_row(FUNC_LOAD,  2, 1600, -2048, -2048, 1'b0, 0));
        directed_plan.push_back(request_row(FUNC_LOAD,  3,    0, -2048,  2047, 1'b0, 0));
        directed_plan.push_back(request_row(FUNC_LOAD,  4, 1023,  1365, -1366, 1'b0, 0));
        directed_plan.push_back(request_row(FUNC_LOAD,  5,  100,    16,     0, 1'b0, 0));
        directed_plan.push_back(request_row(FUNC_LOAD,  6,  100,   -16,     0, 1'b0, 0));
        directed_plan.push_back(request_row(FUNC_LOAD,  7, 1024,    -1,     1, 1'b0, 0));
        directed_plan.push_back(request_row(FUNC_LOAD,  8, 1023,  1365, -1366, 1'b0, 0));
        directed_plan.push_back(request_row(FUNC_LOAD,  9,  400,  -700,   900, 1'b0, 0));
        directed_plan.push_back(request_row(FUNC_LOAD, 10, 1500,   500, -1500, 1'b0, 0));
        directed_plan.push_back(request_row(FUNC_LOAD, 11,   50, -1000, -1000, 1'b0, 0));
        directed_plan.push_back(request_row(FUNC_LOAD, 12,  700,  1800,  -300, 1'b0, 0));
        directed_plan.push_back(request_row(FUNC_LOAD, 13, 1300, -1700,   600, 1'b0, 0));
        directed_plan.push_back(request_row(FUNC_LOAD, 14,  200,  1200,  1500, 1'b0, 0));
        directed_plan.push_back(request_row(FUNC_LOAD, 15,  900,  -300, -1900, 1'b0, 0));
        // Exact hits on the corner entries.
        directed_plan.push_back(request_row(FUNC_QUERY, 15,    0,     0,     0, 1'b1, 0));
        directed_plan.push_back(request_row(FUNC_QUERY,  0, 1600,  2047,  2047, 1'b1, 1));
        directed_plan.push_back(request_row(FUNC_QUERY, 10, 1600, -2048, -2048, 1'b1, 2));
        directed_plan.push_back(request_row(FUNC_QUERY,  5,    0, -2048,  2047, 1'b1, 3));
        // Entries 4 and 8 are identical, so the lower index has to win.
        directed_plan.push_back(request_row(FUNC_QUERY,  8, 1023,  1365, -1366, 1'b1, 4));
        // Halfway between entries 5 and 6.
        directed_plan.push_back(request_row(FUNC_QUERY,  6,  100,     0,     0, 1'b0, 0));
        directed_plan.push_back(request_row(FUNC_QUERY,  3,  900,  -300, -1900, 1'b1, 15));
        // An empty palette always answers with entry 0.
        directed_plan.push_back(length_row(0));
        directed_plan.push_back(request_row(FUNC_QUERY, 12,  800,   100,  -100, 1'b1, 0));
        // A length above the depth searches the whole palette.
        directed_plan.push_back(length_row(31));
        directed_plan.push_back(request_row(FUNC_QUERY,  7,  900,  -300, -1900, 1'b1, 15));
        directed_plan.push_back(length_row(1));
        directed_plan.push_back(request_row(FUNC_QUERY,  1, 1600,  2047,  2047, 1'b1, 0));

        foreach (directed_plan[k]) begin
            if (directed_plan[k].kind == ROW_LENGTH) begin
                write_palette_length(directed_plan[k].length);
            end else begin
                send_request(directed_plan[k].req, directed_plan[k].known,
                             directed_plan[k].known_index);
            end
        end

        phase_lengths = '{16, 0, 1, 31, 2, 8, 17, 15, 16, 0, 0, 16};
        phase_lengths[9]  = $urandom_range(31);
        phase_lengths[10] = $urandom_range(31);

        for (int p = 0; p < PHASES; p++) begin
            write_palette_length(phase_lengths[p][CFG_W-1:0]);
            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                default: begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                end
            endcase
            // The sender keeps offering while the receiver is held off.
            if (p == 0) begin
                hold_asked++;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick          = $urandom_range(99);
                req.slot      = IDX_W'($urandom_range(PALETTE_DEPTH - 1));
                req.color.l   = L_W'($urandom_range(1600));
                req.color.a   = AB_W'($urandom_range(4095));
                req.color.b   = AB_W'($urandom_range(4095));
                if (pick < 25) begin
                    req.func = FUNC_LOAD;
                    // A copy of another entry sets up exact ties.
                    if (pick < 5) begin
                        req.color = palette_colors[$urandom_range(PALETTE_DEPTH - 1)];
                    end
                end else begin
                    req.func = FUNC_QUERY;
                    e = (active_length == 0) ? 0 : $urandom_range(int'(active_length) - 1);
                    case (pick % 4)
                        0: req.color = palette_colors[e];
                        1: begin
                            l = int'(palette_colors[e].l) + int'($urandom_range(80)) - 40;
                            a = int'($signed(palette_colors[e].a))
                                + int'($urandom_range(80)) - 40;
                            b = int'($signed(palette_colors[e].b))
                                + int'($urandom_range(80)) - 40;
                            l = (l < 0) ? 0 : ((l > 1600) ? 1600 : l);
                            a = (a < -2048) ? -2048 : ((a > 2047) ? 2047 : a);
                            b = (b < -2048) ? -2048 : ((b > 2047) ? 2047 : b);
                            req.color.l = l[L_W-1:0];
                            req.color.a = a[AB_W-1:0];
                            req.color.b = b[AB_W-1:0];
                        end
                        2: begin
                            req.color.l = $urandom_range(1) ? 11'd1600 : 11'd0;
                            req.color.a = $urandom_range(1) ? 12'h7FF : 12'h800;
                            req.color.b = $urandom_range(1) ? 12'h7FF : 12'h800;
                        end
                        default: ;
                    endcase
                end
                send_request(req, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        for (int k = 0; k < 100000 && pending_nearest.size() != 0; k++) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (pending_nearest.size() != 0) begin
            mismatches += pending_nearest.size();
            $display("%0d expected results never arrived", pending_nearest.size());
        end
        $display("Sent %0d loads and %0d queries under %0d palette_length writes.",
                 loads_sent, queries_sent, length_writes);
        $display("Compared %0d results with %0d mismatches, one long output stall included.",
                 results_seen, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #10ms;
        $display("Run timed out with %0d results pending.", pending_nearest.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/nplab_pkg.sv
rtl/nplab_palette.sv
rtl/nplab_dist.sv
rtl/nplab_ctrl.sv
rtl/nearest_palette_color_lab.sv
verif/nearest_palette_color_lab_test.sv
